>>> hw/rtl/id_pool_allocator_unit_defines.svh
`ifndef ID_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define ID_POOL_ALLOCATOR_UNIT_DEFINES_SVH
// Assertion helpers clocked on clk, disabled during reset.
`define IPA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ipa check failed");
`define IPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ipa check failed");
`endif

>>> hw/rtl/ipa_pkg.sv
package ipa_pkg;
	localparam int MAX_ID     = 1023;
	localparam int GROUP_SIZE = 64;
	localparam int HYST       = 4;
	localparam int ID_W       = 10;
	localparam int TS_W       = 11;
	localparam int WORD_W     = 32;
	localparam int BIT_W      = 5;
	localparam int WORDS      = (MAX_ID + 1) / WORD_W;
	localparam int ADDR_W     = ID_W - BIT_W;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_RECOMP = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		cmd_t            cmd;
		logic [ID_W-1:0] id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic [1:0]      status;
		logic [ID_W-1:0] highest_id;
		logic [TS_W-1:0] table_size;
	} rsp_t;

	typedef struct packed {
		logic              rd;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] wd_used;
		logic [WORD_W-1:0] wd_freed;
		logic              inval_all;
		logic              inval_freed_all;
		logic              inval_freed_above;
	} mem_req_t;

	typedef enum logic [3:0] {
		S_IDLE, S_A_RD, S_A_CHK, S_N_RD, S_N_CHK, S_F_RD, S_F_CHK,
		S_R_RD, S_R_CHK, S_WR, S_R_WR, S_R_SIZE, S_DONE
	} state_t;
endpackage

>>> hw/rtl/ipa_ram.sv
module ipa_ram #(
	parameter int W = 32,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 rd,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] addr,
	input  logic [W-1:0]         wdata,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (rd) begin
			rdata <= mem[addr];
		end
	end
endmodule

>>> hw/rtl/ipa_rowvld.sv
module ipa_rowvld (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ipa_pkg::mem_req_t             mreq,
	input  logic [ipa_pkg::WORD_W-1:0]    used_raw,
	input  logic [ipa_pkg::WORD_W-1:0]    freed_raw,
	output logic [ipa_pkg::WORD_W-1:0]    used_word,
	output logic [ipa_pkg::WORD_W-1:0]    freed_word
);
	import ipa_pkg::*;

	// One valid bit per row; a row never written since the last clear reads as zero.
	logic [WORDS-1:0]  used_vld_q;
	logic [WORDS-1:0]  freed_vld_q;
	logic [ADDR_W-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_vld_q  <= '0;
			freed_vld_q <= '0;
		end else if (mreq.inval_all) begin
			used_vld_q  <= '0;
			freed_vld_q <= '0;
		end else begin
			for (int r = 0; r < WORDS; r++) begin
				if (mreq.inval_freed_all ||
				    (mreq.inval_freed_above && ADDR_W'(r) > mreq.addr)) begin
					freed_vld_q[r] <= 1'b0;
				end
			end
			if (mreq.we) begin
				used_vld_q[mreq.addr]  <= 1'b1;
				freed_vld_q[mreq.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.rd) begin
			addr_s1 <= mreq.addr;
		end
	end

	assign used_word  = used_vld_q[addr_s1]  ? used_raw  : '0;
	assign freed_word = freed_vld_q[addr_s1] ? freed_raw : '0;
endmodule

>>> hw/rtl/ipa_ctrl.sv
module ipa_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  ipa_pkg::req_t              req,
	output logic                       busy,
	output logic                       done,
	output ipa_pkg::rsp_t              rsp,
	output ipa_pkg::mem_req_t          mreq,
	input  logic [ipa_pkg::WORD_W-1:0] used_word,
	input  logic [ipa_pkg::WORD_W-1:0] freed_word
);
	import ipa_pkg::*;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] addr_q;
	logic [ID_W-1:0]   hid_q, grant_q;
	logic [TS_W-1:0]   ts_q;
	logic [1:0]        status_q;
	logic [WORD_W-1:0] wu_q, wf_q;

	logic [BIT_W-1:0]  lo_bit, hi_bit;
	logic [ID_W-1:0]   hid_inc, top_id, req_id;
	logic [TS_W:0]     ts_x, hid_x, ts_next;
	logic [WORD_W-1:0] lo_mask, keep_mask, inc_mask;

	always_comb begin
		lo_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (freed_word[b]) lo_bit = BIT_W'(b);
		end
		hi_bit = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (used_word[b]) hi_bit = BIT_W'(b);
		end
		for (int b = 0; b < WORD_W; b++) begin
			keep_mask[b] = BIT_W'(b) <= hi_bit;
		end
	end

	assign lo_mask  = WORD_W'(1) << lo_bit;
	assign inc_mask = WORD_W'(1) << grant_q[BIT_W-1:0];
	assign req_id   = {addr_q, {BIT_W{1'b0}}} | ID_W'(wu_q[BIT_W-1:0]);
	assign hid_inc  = hid_q + ID_W'(1);
	assign top_id   = {addr_q, hi_bit};

	// Table resize with hysteresis, evaluated on the updated highest ID.
	always_comb begin
		ts_x    = {1'b0, ts_q};
		hid_x   = (TS_W+1)'(hid_q);
		ts_next = ts_x;
		if (ts_x > (TS_W+1)'(GROUP_SIZE) && ts_x >= (TS_W+1)'(GROUP_SIZE + HYST) &&
		    hid_x < ts_x - (TS_W+1)'(GROUP_SIZE + HYST)) begin
			ts_next = ts_x - (TS_W+1)'(GROUP_SIZE);
		end else if (ts_x != '0 && hid_x >= ts_x - (TS_W+1)'(1)) begin
			ts_next = ts_x + (TS_W+1)'(GROUP_SIZE);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.cmd)
						CMD_ALLOC:  state_d = S_A_RD;
						CMD_FREE:   state_d = (req.id == '0) ? S_DONE : S_F_RD;
						CMD_RECOMP: state_d = S_R_RD;
						CMD_CLEAR:  state_d = S_DONE;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_A_RD:  state_d = S_A_CHK;
			S_A_CHK: begin
				if (freed_word != '0) state_d = S_WR;
				else if (addr_q == ADDR_W'(WORDS - 1))
					state_d = (hid_q >= ID_W'(MAX_ID)) ? S_DONE : S_N_RD;
				else state_d = S_A_RD;
			end
			S_N_RD:  state_d = S_N_CHK;
			S_N_CHK: state_d = S_WR;
			S_F_RD:  state_d = S_F_CHK;
			S_F_CHK: state_d = S_WR;
			S_R_RD:  state_d = S_R_CHK;
			S_R_CHK: begin
				if (used_word != '0) state_d = (top_id == hid_q) ? S_DONE : S_R_WR;
				else if (addr_q == '0) state_d = S_R_SIZE;
				else state_d = S_R_RD;
			end
			S_WR:     state_d = S_DONE;
			S_R_WR:   state_d = S_R_SIZE;
			S_R_SIZE: state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mreq          = '0;
		mreq.addr     = addr_q;
		mreq.wd_used  = wu_q;
		mreq.wd_freed = wf_q;
		case (state_q)
			S_A_RD, S_N_RD, S_F_RD, S_R_RD: mreq.rd = 1'b1;
			S_WR:  mreq.we = 1'b1;
			S_R_WR: begin
				mreq.we                = 1'b1;
				mreq.inval_freed_above = 1'b1;
			end
			S_R_CHK: mreq.inval_freed_all = (used_word == '0) && (addr_q == '0);
			S_IDLE:  mreq.inval_all = start && (req.cmd == CMD_CLEAR);
			default: mreq.rd = 1'b0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp  = '{granted_id: grant_q, status: status_q, highest_id: hid_q,
	                table_size: ts_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hid_q    <= '0;
			ts_q     <= TS_W'(GROUP_SIZE);
			status_q <= ST_OK;
			grant_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= ST_OK;
						grant_q  <= '0;
						if (req.cmd == CMD_FREE && req.id == '0) status_q <= ST_ZERO;
						if (req.cmd == CMD_CLEAR) hid_q <= '0;
					end
				end
				S_A_CHK: begin
					if (freed_word != '0) begin
						grant_q <= {addr_q, lo_bit};
					end else if (addr_q == ADDR_W'(WORDS - 1)) begin
						if (hid_q >= ID_W'(MAX_ID)) begin
							status_q <= ST_FULL;
						end else begin
							hid_q   <= hid_inc;
							grant_q <= hid_inc;
						end
					end
				end
				S_R_CHK: begin
					if (used_word != '0) hid_q <= top_id;
					else if (addr_q == '0) hid_q <= '0;
				end
				S_R_SIZE: ts_q <= ts_next[TS_W-1:0];
				default: ts_q <= ts_q;
			endcase
		end
	end

	// Scan address and the word images to be written back.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				case (req.cmd)
					CMD_ALLOC:  addr_q <= '0;
					CMD_RECOMP: addr_q <= ADDR_W'(WORDS - 1);
					default:    addr_q <= req.id[ID_W-1:BIT_W];
				endcase
				wu_q <= WORD_W'(req.id[BIT_W-1:0]);
			end
			S_A_CHK: begin
				if (freed_word != '0) begin
					wu_q <= used_word | lo_mask;
					wf_q <= freed_word & ~lo_mask;
				end else if (addr_q == ADDR_W'(WORDS - 1)) begin
					addr_q <= hid_inc[ID_W-1:BIT_W];
				end else begin
					addr_q <= addr_q + ADDR_W'(1);
				end
			end
			S_N_CHK: begin
				wu_q <= used_word | inc_mask;
				wf_q <= freed_word;
			end
			S_F_CHK: begin
				wu_q <= used_word & ~(WORD_W'(1) << req_id[BIT_W-1:0]);
				wf_q <= freed_word | (WORD_W'(1) << req_id[BIT_W-1:0]);
			end
			S_R_CHK: begin
				if (used_word != '0) begin
					wu_q <= used_word;
					wf_q <= freed_word & keep_mask;
				end else if (addr_q != '0) begin
					addr_q <= addr_q - ADDR_W'(1);
				end
			end
			default: addr_q <= addr_q;
		endcase
	end
endmodule

>>> hw/rtl/id_pool_allocator_unit.sv
// Allocate reads and checks each 32-bit word scanned, with a further read for a new ID;
// free reads one word, recompute scans downward, clear and a rejected free go to done.
// Throughput: one transaction at a time; busy stays high through the done cycle, so the
// next transaction is taken at the earliest in the cycle after done.
// The result is shown for one cycle with done; the receiver cannot stall.
// Reset is asynchronous: maps read as empty through row valid bits, highest ID 0, one group.
module id_pool_allocator_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ipa_pkg::req_t  req,
	output logic           busy,
	output logic           done,
	output ipa_pkg::rsp_t  rsp
);
	import ipa_pkg::*;

	mem_req_t          mreq;
	logic [WORD_W-1:0] used_raw, freed_raw, used_word, freed_word;

	ipa_ctrl u_ctrl (
		.clk, .arst_n, .start, .req, .busy, .done, .rsp, .mreq,
		.used_word, .freed_word
	);

	ipa_ram #(.W(WORD_W), .D(WORDS)) u_used_ram (
		.clk, .rd(mreq.rd), .we(mreq.we), .addr(mreq.addr),
		.wdata(mreq.wd_used), .rdata(used_raw)
	);

	ipa_ram #(.W(WORD_W), .D(WORDS)) u_freed_ram (
		.clk, .rd(mreq.rd), .we(mreq.we), .addr(mreq.addr),
		.wdata(mreq.wd_freed), .rdata(freed_raw)
	);

	ipa_rowvld u_rowvld (
		.clk, .arst_n, .mreq, .used_raw, .freed_raw, .used_word, .freed_word
	);
endmodule

>>> hw/rtl/ipa_checker.sv
`include "id_pool_allocator_unit_defines.svh"
module ipa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input ipa_pkg::rsp_t rsp
);
	import ipa_pkg::*;

	`IPA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`IPA_ASSERT_SAME(a_done_busy, done, busy)
	`IPA_ASSERT_NEXT(a_done_idle, done, !busy && !done)
	`IPA_ASSERT_SAME(a_full_nogrant, done && rsp.status == ST_FULL, rsp.granted_id == '0)
endmodule

bind id_pool_allocator_unit ipa_checker u_ipa_checker (
	.clk, .arst_n, .start, .busy, .done, .rsp
);

>>> test/id_pool_allocator_unit_tb.sv
module id_pool_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ipa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	id_pool_allocator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always #2 clk = ~clk;

	// Shadow copy of the pool.
	bit used_ids[MAX_ID+1];
	bit freed_ids[MAX_ID+1];
	int unsigned top_id;
	int unsigned tbl_size;

	req_t cmd_queue[$];
	rsp_t expected_rsps[$];
	bit failed = 1'b0;
	bit calm = 1'b0;
	int unsigned issued = 0;

	function automatic void resize_tbl();
		if (tbl_size > GROUP_SIZE && tbl_size >= GROUP_SIZE + HYST &&
				top_id < tbl_size - GROUP_SIZE - HYST) begin
			tbl_size -= GROUP_SIZE;
		end else if (tbl_size >= 1 && top_id >= tbl_size - 1) begin
			tbl_size += GROUP_SIZE;
		end
	endfunction

	function automatic rsp_t apply_cmd(req_t r);
		rsp_t o;
		int lo;
		int hi;
		o = '0;
		case (r.cmd)
			CMD_ALLOC: begin
				lo = -1;
				for (int i = 0; i <= MAX_ID; i++)
					if (freed_ids[i] && lo < 0) lo = i;
				if (lo >= 0) begin
					o.granted_id = ID_W'(lo);
					freed_ids[lo] = 1'b0;
					used_ids[lo] = 1'b1;
				end else if (top_id >= MAX_ID) begin
					o.status = ST_FULL;
				end else begin
					top_id++;
					o.granted_id = ID_W'(top_id);
					used_ids[top_id] = 1'b1;
				end
			end
			CMD_FREE: begin
				if (r.id == 0) o.status = ST_ZERO;
				else begin
					used_ids[r.id] = 1'b0;
					freed_ids[r.id] = 1'b1;
				end
			end
			CMD_RECOMP: begin
				hi = -1;
				for (int i = 0; i <= MAX_ID; i++)
					if (used_ids[i]) hi = i;
				if (hi < 0) begin
					top_id = 0;
					freed_ids = '{default: 1'b0};
					resize_tbl();
				end else if (hi != top_id) begin
					top_id = hi;
					for (int i = hi + 1; i <= MAX_ID; i++) freed_ids[i] = 1'b0;
					resize_tbl();
				end
			end
			default: begin
				top_id = 0;
				used_ids = '{default: 1'b0};
				freed_ids = '{default: 1'b0};
			end
		endcase
		o.highest_id = ID_W'(top_id);
		o.table_size = TS_W'(tbl_size);
		return o;
	endfunction

	function automatic req_t mk(cmd_t c, int unsigned i);
		req_t r;
		r.cmd = c;
		r.id = ID_W'(i);
		return r;
	endfunction

	// A transaction is taken when start is high and busy is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_rsps.push_back(apply_cmd(req));
				issued++;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
				start <= 1'b1;
				req <= cmd_queue.pop_front();
			end else begin
				start <= 1'b0;
				req <= mk(cmd_t'($urandom_range(3)), $urandom_range(MAX_ID));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result %p", $time, rsp);
				failed = 1'b1;
			end else begin
				rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp.granted_id !== e.granted_id || rsp.status !== e.status ||
						rsp.highest_id !== e.highest_id ||
						rsp.table_size !== e.table_size) begin
					$display("%0t: expected %p actual %p", $time, e, rsp);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		int unsigned total;
		int unsigned n;
		used_ids = '{default: 1'b0};
		freed_ids = '{default: 1'b0};
		top_id = 0;
		tbl_size = GROUP_SIZE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty recompute, free of zero, a free of the never-allocated ID 1023,
		// reuse of the lowest freed ID, and clear.
		cmd_queue.push_back(mk(CMD_RECOMP, 0));
		cmd_queue.push_back(mk(CMD_FREE, 0));
		cmd_queue.push_back(mk(CMD_ALLOC, 1023));
		cmd_queue.push_back(mk(CMD_ALLOC, 0));
		cmd_queue.push_back(mk(CMD_ALLOC, 0));
		cmd_queue.push_back(mk(CMD_FREE, 1023));
		cmd_queue.push_back(mk(CMD_FREE, 2));
		cmd_queue.push_back(mk(CMD_ALLOC, 0));
		cmd_queue.push_back(mk(CMD_ALLOC, 0));
		cmd_queue.push_back(mk(CMD_RECOMP, 0));
		cmd_queue.push_back(mk(CMD_RECOMP, 0));
		cmd_queue.push_back(mk(CMD_FREE, 3));
		cmd_queue.push_back(mk(CMD_RECOMP, 0));
		cmd_queue.push_back(mk(CMD_CLEAR, 0));
		cmd_queue.push_back(mk(CMD_RECOMP, 0));
		// Fill the whole pool to reach exhaustion, then recompute with the highest ID unchanged.
		for (int i = 0; i < MAX_ID + 1; i++) cmd_queue.push_back(mk(CMD_ALLOC, 0));
		cmd_queue.push_back(mk(CMD_RECOMP, 0));
		cmd_queue.push_back(mk(CMD_FREE, 512));
		cmd_queue.push_back(mk(CMD_FREE, 1));
		cmd_queue.push_back(mk(CMD_ALLOC, 0));
		cmd_queue.push_back(mk(CMD_CLEAR, 0));

		total = cmd_queue.size();
		while (total < 1900) begin
			n = $urandom_range(60, 5);
			for (int k = 0; k < n; k++) begin
				int unsigned p;
				p = $urandom_range(99);
				if (p < 45) cmd_queue.push_back(mk(CMD_ALLOC, $urandom_range(MAX_ID)));
				else if (p < 80) cmd_queue.push_back(mk(CMD_FREE,
						$urandom_range(3) == 0 ? $urandom_range(MAX_ID) : $urandom_range(80)));
				else cmd_queue.push_back(mk(CMD_RECOMP, $urandom_range(MAX_ID)));
			end
			// Recompute runs: recompute repeatedly.
			if ($urandom_range(3) == 0) begin
				for (int k = 0; k < 8; k++) cmd_queue.push_back(mk(CMD_RECOMP, 0));
			end
			if ($urandom_range(9) == 0) cmd_queue.push_back(mk(CMD_CLEAR, $urandom_range(MAX_ID)));
			total = cmd_queue.size();
		end

		fork
			begin
				wait (issued > 1100);
				calm = 1'b1;
				wait (issued > 1500);
				calm = 1'b0;
			end
		join_none
		wait (cmd_queue.size() == 0 && !start);
		wait (expected_rsps.size() == 0);
		repeat (80) @(posedge clk);
		if (!failed && expected_rsps.size() == 0) begin
			$display("id_pool_allocator_unit: match");
		end else begin
			$display("id_pool_allocator_unit: mismatch");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("id_pool_allocator_unit: mismatch");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ipa_pkg.sv
hw/rtl/ipa_ram.sv
hw/rtl/ipa_rowvld.sv
hw/rtl/ipa_ctrl.sv
hw/rtl/id_pool_allocator_unit.sv
hw/rtl/ipa_checker.sv
test/id_pool_allocator_unit_tb.sv
